/* hw/rtl/kwm_pkg.sv */
package kwm_pkg;

    // sizing
    localparam int MAX_LISTS   = 64;
    localparam int LIST_DEPTH  = 1024;
    localparam int DATA_WIDTH  = 32;

    localparam int LIDX_W      = $clog2(MAX_LISTS);
    localparam int CNT_W       = $clog2(MAX_LISTS + 1);
    localparam int FILL_W      = $clog2(LIST_DEPTH + 1);
    localparam int STORE_DEPTH = MAX_LISTS * LIST_DEPTH;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int META_W      = 2 * FILL_W;
    localparam int CFG_W       = 7;
    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 3;

    localparam int LIST_COUNT_RESET = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADIDX = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ORDER  = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_PUSH_CHK,
        S_PUSH_ORD,
        S_POP_SCAN,
        S_POP_FIN,
        S_DONE
    } state_t;

endpackage

/* hw/rtl/kwm_ram.sv */
module kwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/k_way_sorted_list_merger_core.sv */
// K-way merger of ascending lists. Each accepted word is a push, a pop, a
// clear or a no-op request and yields exactly one result word. Elements
// live in one 64K-entry registered-read RAM (list i at slot i*LIST_DEPTH+pos);
// per-list fill and head counters live in a small RAM with one valid flop
// per list, so reset and clear take effect at once with no clearing pass.
// A push goes through decode, counter read, last-value read, compare and
// write, result and idle; into an empty or a full list it skips the compare
// step. A pop scans the lists in use one per cycle through a three-stage
// read pipeline (counter read, head-element read, compare). A clear, an
// unknown request or a bad index goes from decode straight to the result.
// The result register lets the next word enter while a result waits; only
// a second result held behind a stalled one holds the block back.
module k_way_sorted_list_merger_core
    import kwm_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration
    input  logic                        cfg_we,
    input  logic [CFG_W-1:0]            cfg_wdata,
    // request channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [REQ_W-1:0]            req_type,
    input  logic [LIDX_W-1:0]           list_index,
    input  logic signed [DATA_WIDTH-1:0] elem_value,
    // result channel
    output logic                        res_valid,
    input  logic                        res_stall,
    output logic signed [DATA_WIDTH-1:0] out_value,
    output logic                        out_valid,
    output logic                        out_last,
    output logic [STATUS_W-1:0]         status
);

    state_t state_reg, state_next;

    logic [CFG_W-1:0]       cfg_count_reg;
    logic [CNT_W-1:0]       cnt_in_use;

    // captured request
    logic [REQ_W-1:0]       req_reg;
    logic [LIDX_W-1:0]      idx_reg;
    logic [DATA_WIDTH-1:0]  val_reg;

    // push scratch
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [FILL_W-1:0]      head_reg, head_next;

    // pop scan pipeline
    logic [CNT_W-1:0]       scan_reg, scan_next;
    logic                   p1_v_reg, p1_v_next;
    logic [LIDX_W-1:0]      p1_idx_reg, p1_idx_next;
    logic                   p2_v_reg, p2_v_next;
    logic                   p2_ne_reg, p2_ne_next;
    logic [LIDX_W-1:0]      p2_idx_reg, p2_idx_next;
    logic [FILL_W-1:0]      p2_head_reg, p2_head_next;
    logic [FILL_W-1:0]      p2_fill_reg, p2_fill_next;
    logic                   found_reg, found_next;
    logic [1:0]             ne_cnt_reg, ne_cnt_next;
    logic [LIDX_W-1:0]      best_idx_reg, best_idx_next;
    logic [DATA_WIDTH-1:0]  best_val_reg, best_val_next;
    logic [FILL_W-1:0]      best_head_reg, best_head_next;
    logic [FILL_W-1:0]      best_fill_reg, best_fill_next;

    // staged result
    logic [DATA_WIDTH-1:0]  st_value_reg, st_value_next;
    logic                   st_ovalid_reg, st_ovalid_next;
    logic                   st_last_reg, st_last_next;
    logic [STATUS_W-1:0]    st_status_reg, st_status_next;

    // output register
    logic                   res_valid_reg, res_valid_next;
    logic [DATA_WIDTH-1:0]  res_value_reg;
    logic                   res_ovalid_reg;
    logic                   res_last_reg;
    logic [STATUS_W-1:0]    res_status_reg;
    logic                   res_load;

    // meta RAM ({fill, head}) and its valid bits
    logic [MAX_LISTS-1:0]   meta_vld_reg, meta_vld_next;
    logic                   meta_rvld_reg;
    logic                   meta_we, meta_re;
    logic [LIDX_W-1:0]      meta_waddr, meta_raddr;
    logic [META_W-1:0]      meta_wdata, meta_rdata;
    logic [FILL_W-1:0]      rd_fill, rd_head;

    // element RAM
    logic                   elem_we, elem_re;
    logic [STORE_AW-1:0]    elem_waddr, elem_raddr;
    logic [DATA_WIDTH-1:0]  elem_wdata, elem_rdata;

    logic                   accept;
    logic                   scan_issue;
    logic                   scan_done;
    logic                   push_wr_chk, push_wr_ord;

    // lists in use, clamped to 1..MAX_LISTS
    always_comb
    begin
        if (cfg_count_reg == '0)
        begin
            cnt_in_use = CNT_W'(1);
        end
        else if (int'(cfg_count_reg) > MAX_LISTS)
        begin
            cnt_in_use = CNT_W'(MAX_LISTS);
        end
        else
        begin
            cnt_in_use = CNT_W'(cfg_count_reg);
        end
    end

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);

    // unwritten meta entries read as zero
    assign rd_fill = meta_rvld_reg ? meta_rdata[META_W-1:FILL_W] : '0;
    assign rd_head = meta_rvld_reg ? meta_rdata[FILL_W-1:0] : '0;

    assign scan_issue = (state_reg == S_POP_SCAN) && (scan_reg < cnt_in_use);
    assign scan_done  = (scan_reg >= cnt_in_use) && !p1_v_reg && !p2_v_reg;

    assign push_wr_chk = (state_reg == S_PUSH_CHK) && (rd_fill < FILL_W'(LIST_DEPTH))
                         && (rd_fill == '0);
    assign push_wr_ord = (state_reg == S_PUSH_ORD)
                         && !($signed(val_reg) < $signed(elem_rdata));

    assign res_load = (state_reg == S_DONE) && (!res_valid_reg || !res_stall);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (req_reg == REQ_PUSH && CNT_W'(idx_reg) < cnt_in_use)
                begin
                    state_next = S_PUSH_CHK;
                end
                else if (req_reg == REQ_POP)
                begin
                    state_next = S_POP_SCAN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_PUSH_CHK:
            begin
                if (rd_fill < FILL_W'(LIST_DEPTH) && rd_fill != '0)
                begin
                    state_next = S_PUSH_ORD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_PUSH_ORD:
            begin
                state_next = S_DONE;
            end
            S_POP_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_POP_FIN;
                end
            end
            S_POP_FIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        fill_next      = fill_reg;
        head_next      = head_reg;
        scan_next      = scan_reg;
        p1_v_next      = 1'b0;
        p1_idx_next    = p1_idx_reg;
        p2_v_next      = 1'b0;
        p2_ne_next     = p2_ne_reg;
        p2_idx_next    = p2_idx_reg;
        p2_head_next   = p2_head_reg;
        p2_fill_next   = p2_fill_reg;
        found_next     = found_reg;
        ne_cnt_next    = ne_cnt_reg;
        best_idx_next  = best_idx_reg;
        best_val_next  = best_val_reg;
        best_head_next = best_head_reg;
        best_fill_next = best_fill_reg;
        st_value_next  = st_value_reg;
        st_ovalid_next = st_ovalid_reg;
        st_last_next   = st_last_reg;
        st_status_next = st_status_reg;
        meta_vld_next  = meta_vld_reg;

        meta_re    = 1'b0;
        meta_raddr = idx_reg;
        meta_we    = 1'b0;
        meta_waddr = idx_reg;
        meta_wdata = {fill_reg + FILL_W'(1), head_reg};
        elem_re    = 1'b0;
        elem_raddr = '0;
        elem_we    = 1'b0;
        elem_waddr = STORE_AW'(idx_reg) * STORE_AW'(LIST_DEPTH) + STORE_AW'(fill_reg);
        elem_wdata = val_reg;

        case (state_reg)
            S_DECODE:
            begin
                st_value_next  = '0;
                st_ovalid_next = 1'b0;
                st_last_next   = 1'b0;
                st_status_next = ST_OK;
                scan_next      = '0;
                found_next     = 1'b0;
                ne_cnt_next    = '0;
                if (req_reg == REQ_PUSH)
                begin
                    if (CNT_W'(idx_reg) >= cnt_in_use)
                    begin
                        st_status_next = ST_BADIDX;
                    end
                    else
                    begin
                        meta_re = 1'b1;
                    end
                end
                else if (req_reg == REQ_CLEAR)
                begin
                    meta_vld_next = '0;
                end
            end
            S_PUSH_CHK:
            begin
                fill_next = rd_fill;
                head_next = rd_head;
                if (rd_fill >= FILL_W'(LIST_DEPTH))
                begin
                    st_status_next = ST_FULL;
                end
                else if (rd_fill != '0)
                begin
                    // fetch the last value written to this list
                    elem_re    = 1'b1;
                    elem_raddr = STORE_AW'(idx_reg) * STORE_AW'(LIST_DEPTH)
                                 + STORE_AW'(rd_fill - FILL_W'(1));
                end
                if (push_wr_chk)
                begin
                    elem_we    = 1'b1;
                    elem_waddr = STORE_AW'(idx_reg) * STORE_AW'(LIST_DEPTH);
                    meta_we    = 1'b1;
                    meta_wdata = {FILL_W'(1), rd_head};
                    meta_vld_next[idx_reg] = 1'b1;
                end
            end
            S_PUSH_ORD:
            begin
                if (push_wr_ord)
                begin
                    elem_we = 1'b1;
                    meta_we = 1'b1;
                    meta_vld_next[idx_reg] = 1'b1;
                end
                else
                begin
                    st_status_next = ST_ORDER;
                end
            end
            S_POP_SCAN:
            begin
                // stage 0: read the counters of the next list
                if (scan_issue)
                begin
                    meta_re     = 1'b1;
                    meta_raddr  = scan_reg[LIDX_W-1:0];
                    p1_v_next   = 1'b1;
                    p1_idx_next = scan_reg[LIDX_W-1:0];
                    scan_next   = scan_reg + CNT_W'(1);
                end
                // stage 1: read the head element of a nonempty list
                if (p1_v_reg)
                begin
                    p2_v_next    = 1'b1;
                    p2_idx_next  = p1_idx_reg;
                    p2_head_next = rd_head;
                    p2_fill_next = rd_fill;
                    p2_ne_next   = (rd_head < rd_fill);
                    if (rd_head < rd_fill)
                    begin
                        elem_re    = 1'b1;
                        elem_raddr = STORE_AW'(p1_idx_reg) * STORE_AW'(LIST_DEPTH)
                                     + STORE_AW'(rd_head);
                    end
                end
                // stage 2: keep the smallest head, lower list wins ties
                if (p2_v_reg && p2_ne_reg)
                begin
                    if (ne_cnt_reg != 2'd2)
                    begin
                        ne_cnt_next = ne_cnt_reg + 2'd1;
                    end
                    if (!found_reg || $signed(elem_rdata) < $signed(best_val_reg))
                    begin
                        found_next     = 1'b1;
                        best_idx_next  = p2_idx_reg;
                        best_val_next  = elem_rdata;
                        best_head_next = p2_head_reg;
                        best_fill_next = p2_fill_reg;
                    end
                end
            end
            S_POP_FIN:
            begin
                if (!found_reg)
                begin
                    st_status_next = ST_EMPTY;
                end
                else
                begin
                    st_value_next  = best_val_reg;
                    st_ovalid_next = 1'b1;
                    st_last_next   = !((ne_cnt_reg == 2'd2)
                                       || (best_head_reg + FILL_W'(1) < best_fill_reg));
                    meta_we        = 1'b1;
                    meta_waddr     = best_idx_reg;
                    meta_wdata     = {best_fill_reg, best_head_reg + FILL_W'(1)};
                    meta_vld_next[best_idx_reg] = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // output register
    always_comb
    begin
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cfg_count_reg <= CFG_W'(LIST_COUNT_RESET);
            meta_vld_reg  <= '0;
            res_valid_reg <= 1'b0;
            p1_v_reg      <= 1'b0;
            p2_v_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            meta_vld_reg  <= meta_vld_next;
            res_valid_reg <= res_valid_next;
            p1_v_reg      <= p1_v_next;
            p2_v_reg      <= p2_v_next;
            if (cfg_we)
            begin
                cfg_count_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_type;
            idx_reg <= list_index;
            val_reg <= elem_value;
        end
        if (meta_re)
        begin
            meta_rvld_reg <= meta_vld_reg[meta_raddr];
        end
        fill_reg       <= fill_next;
        head_reg       <= head_next;
        scan_reg       <= scan_next;
        p1_idx_reg     <= p1_idx_next;
        p2_ne_reg      <= p2_ne_next;
        p2_idx_reg     <= p2_idx_next;
        p2_head_reg    <= p2_head_next;
        p2_fill_reg    <= p2_fill_next;
        found_reg      <= found_next;
        ne_cnt_reg     <= ne_cnt_next;
        best_idx_reg   <= best_idx_next;
        best_val_reg   <= best_val_next;
        best_head_reg  <= best_head_next;
        best_fill_reg  <= best_fill_next;
        st_value_reg   <= st_value_next;
        st_ovalid_reg  <= st_ovalid_next;
        st_last_reg    <= st_last_next;
        st_status_reg  <= st_status_next;
        if (res_load)
        begin
            res_value_reg  <= st_value_reg;
            res_ovalid_reg <= st_ovalid_reg;
            res_last_reg   <= st_last_reg;
            res_status_reg <= st_status_reg;
        end
    end

    // per-list fill and head counters
    kwm_ram #(
        .WIDTH (META_W),
        .DEPTH (MAX_LISTS)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .re    (meta_re),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    // element store
    kwm_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_elem_ram (
        .clk   (clk),
        .we    (elem_we),
        .waddr (elem_waddr),
        .wdata (elem_wdata),
        .re    (elem_re),
        .raddr (elem_raddr),
        .rdata (elem_rdata)
    );

    assign res_valid = res_valid_reg;
    assign out_value = res_value_reg;
    assign out_valid = res_ovalid_reg;
    assign out_last  = res_last_reg;
    assign status    = res_status_reg;

endmodule

/* tb/sv/k_way_sorted_list_merger_core_tb.sv */
module k_way_sorted_list_merger_core_tb
    import kwm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // request code the block treats as a no-op
    localparam logic [REQ_W-1:0] REQ_NOP = 2'd3;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic                         valid;
        logic                         last;
        logic [STATUS_W-1:0]          st;
    } merge_result_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    logic [CFG_W-1:0]             cfg_wdata = '0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [REQ_W-1:0]             req_type = REQ_NOP;
    logic [LIDX_W-1:0]            list_index = '0;
    logic signed [DATA_WIDTH-1:0] elem_value = '0;
    logic                         res_valid;
    logic                         res_stall = 1'b0;
    logic signed [DATA_WIDTH-1:0] out_value;
    logic                         out_valid;
    logic                         out_last;
    logic [STATUS_W-1:0]          status;

    // predicted block state
    logic signed [DATA_WIDTH-1:0] elem_mem [STORE_DEPTH];
    int                           fill_cnt [MAX_LISTS];
    int                           head_cnt [MAX_LISTS];
    int                           list_count_reg;

    merge_result_t merge_results_q [$];
    int            mismatch_cnt = 0;
    int            idle_pct = 31;

    k_way_sorted_list_merger_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .list_index (list_index),
        .elem_value (elem_value),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .out_value  (out_value),
        .out_valid  (out_valid),
        .out_last   (out_last),
        .status     (status)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // lists actually scanned: 0 acts as 1, above MAX_LISTS saturates
    function automatic int active_lists();
        if (list_count_reg == 0)
            return 1;
        if (list_count_reg > MAX_LISTS)
            return MAX_LISTS;
        return list_count_reg;
    endfunction

    // next result of the merger for one word, updates predicted state
    function automatic merge_result_t merge_predict(logic [REQ_W-1:0] req,
                                                    logic [LIDX_W-1:0] idx,
                                                    logic signed [DATA_WIDTH-1:0] val);
        merge_result_t r;
        int            cnt;
        int            best;
        bit            found;
        bit            more;
        int            slot;
        r = '0;
        r.st = ST_OK;
        cnt = active_lists();
        found = 1'b0;
        more = 1'b0;
        best = 0;
        case (req)
            REQ_PUSH:
            begin
                if (int'(idx) >= cnt)
                    r.st = ST_BADIDX;
                else if (fill_cnt[idx] >= LIST_DEPTH)
                    r.st = ST_FULL;
                else
                begin
                    slot = int'(idx) * LIST_DEPTH + fill_cnt[idx];
                    if (fill_cnt[idx] > 0 && val < elem_mem[slot-1])
                        r.st = ST_ORDER;
                    else
                    begin
                        elem_mem[slot] = val;
                        fill_cnt[idx]++;
                    end
                end
            end
            REQ_POP:
            begin
                // smallest head, lowest index wins ties
                for (int i = 0; i < cnt; i++)
                    if (head_cnt[i] < fill_cnt[i])
                        if (!found ||
                            elem_mem[i*LIST_DEPTH+head_cnt[i]] <
                            elem_mem[best*LIST_DEPTH+head_cnt[best]])
                        begin
                            found = 1'b1;
                            best = i;
                        end
                if (!found)
                    r.st = ST_EMPTY;
                else
                begin
                    r.value = elem_mem[best*LIST_DEPTH+head_cnt[best]];
                    r.valid = 1'b1;
                    head_cnt[best]++;
                    for (int i = 0; i < cnt; i++)
                        if (head_cnt[i] < fill_cnt[i])
                            more = 1'b1;
                    r.last = !more;
                end
            end
            REQ_CLEAR:
            begin
                for (int i = 0; i < MAX_LISTS; i++)
                begin
                    fill_cnt[i] = 0;
                    head_cnt[i] = 0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // send one word; valid stays up after acceptance unless a gap follows
    task automatic send_word(logic [REQ_W-1:0] req, int idx,
                             logic signed [DATA_WIDTH-1:0] val);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= req;
        list_index <= LIDX_W'(idx);
        elem_value <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        merge_results_q.push_back(merge_predict(req, LIDX_W'(idx), val));
    endtask

    // hold off the sender until every outstanding result is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (merge_results_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_list_count(int value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value[CFG_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        list_count_reg = value & 7'h7F;
    endtask

    // value that keeps list idx ascending, ties frequent
    function automatic logic signed [DATA_WIDTH-1:0] sorted_value(int idx);
        longint last_v;
        longint nxt;
        if (fill_cnt[idx] == 0)
        begin
            if ($urandom_range(0, 1))
                return $urandom;
            return int'($urandom_range(0, 15)) - 8;
        end
        last_v = elem_mem[idx*LIST_DEPTH+fill_cnt[idx]-1];
        case ($urandom_range(0, 9))
            0, 1, 2: nxt = last_v;
            3:       nxt = last_v + longint'($urandom);
            default: nxt = last_v + longint'($urandom_range(1, 64));
        endcase
        if (nxt > 64'sd2147483647)
            nxt = 64'sd2147483647;
        return nxt[DATA_WIDTH-1:0];
    endfunction

    // value below the last one written to list idx
    function automatic logic signed [DATA_WIDTH-1:0] unsorted_value(int idx);
        longint last_v;
        longint nxt;
        last_v = elem_mem[idx*LIST_DEPTH+fill_cnt[idx]-1];
        nxt = last_v - 1 - longint'($urandom_range(0, 1000));
        if (nxt < -64'sd2147483648)
            nxt = -64'sd2147483648;
        return nxt[DATA_WIDTH-1:0];
    endfunction

    // result checker
    always @(posedge clk)
    begin : result_check
        merge_result_t exp_r;
        if (rst_n && res_valid && !res_stall)
        begin
            if (merge_results_q.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result word: value %0d valid %0b last %0b status %0d",
                             out_value, out_valid, out_last, status);
            end
            else
            begin
                exp_r = merge_results_q.pop_front();
                if (out_value !== exp_r.value || out_valid !== exp_r.valid ||
                    out_last !== exp_r.last || status !== exp_r.st)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp %0d/%0b/%0b/%0d got %0d/%0b/%0b/%0d",
                                 exp_r.value, exp_r.valid, exp_r.last, exp_r.st,
                                 out_value, out_valid, out_last, status);
                end
            end
        end
    end

    // result-side backpressure
    always @(posedge clk)
        res_stall <= ($urandom_range(0, 99) < idle_pct);

    // special cases in a short fixed sequence
    task automatic test_directed();
        // reset count of two lists
        send_word(REQ_PUSH, 1, 32'sh7FFFFFFF);
        send_word(REQ_PUSH, 2, 5);                    // index beyond count
        send_word(REQ_PUSH, 0, 32'sh80000000);
        send_word(REQ_POP, 63, $urandom);
        send_word(REQ_POP, 0, $urandom);              // last element
        send_word(REQ_POP, 0, 0);                     // empty
        send_word(REQ_NOP, 63, $urandom);
        send_word(REQ_PUSH, 1, 5);                    // below popped last value
        send_word(REQ_CLEAR, 63, -1);
        send_word(REQ_PUSH, 1, 5);
        // ties across the full list range
        set_list_count(MAX_LISTS);
        send_word(REQ_PUSH, 63, 5);
        send_word(REQ_PUSH, 0, -1);
        send_word(REQ_PUSH, 63, 5);
        repeat (4) send_word(REQ_POP, $urandom, $urandom);
        // lists above a lowered count are hidden, not lost
        set_list_count(4);
        send_word(REQ_PUSH, 3, 10);
        send_word(REQ_PUSH, 2, 7);
        set_list_count(2);
        send_word(REQ_POP, 0, 0);
        set_list_count(4);
        send_word(REQ_POP, 0, 0);
        send_word(REQ_POP, 0, 0);
        // zero count acts as one list
        set_list_count(0);
        send_word(REQ_PUSH, 1, 0);
        send_word(REQ_PUSH, 0, 0);
        send_word(REQ_POP, 0, 0);
    endtask

    // fill one list to depth, then check full handling and slot non-reuse
    task automatic test_full_list();
        set_list_count(1);
        send_word(REQ_CLEAR, 0, 0);
        idle_pct = 0;
        for (int i = 0; i < LIST_DEPTH; i++)
            send_word(REQ_PUSH, 0, sorted_value(0));
        idle_pct = 31;
        wait_drained();
        send_word(REQ_PUSH, 0, 32'sh7FFFFFFF);
        send_word(REQ_PUSH, 0, 32'sh80000000);        // full beats order
        send_word(REQ_PUSH, 5, 0);                    // index beats full
        send_word(REQ_POP, 0, 0);
        send_word(REQ_POP, 0, 0);
        send_word(REQ_PUSH, 0, 32'sh7FFFFFFF);        // popped slots stay used
        send_word(REQ_CLEAR, 0, 0);
        send_word(REQ_PUSH, 0, 32'sh80000000);
        send_word(REQ_POP, 0, 0);
    endtask

    // mostly well-formed traffic with some noise
    task automatic run_random_phase(int n_words, bit do_pause);
        int cnt;
        int pick;
        int idx;
        for (int k = 0; k < n_words; k++)
        begin
            if (do_pause && k == n_words / 2)
                wait_drained();
            cnt = active_lists();
            pick = $urandom_range(0, 99);
            idx = $urandom_range(0, cnt - 1);
            if (pick < 52)
                send_word(REQ_PUSH, idx, sorted_value(idx));
            else if (pick < 86)
                send_word(REQ_POP, $urandom, $urandom);
            else if (pick < 91)
            begin
                if (fill_cnt[idx] > 0 &&
                    elem_mem[idx*LIST_DEPTH+fill_cnt[idx]-1] != 32'sh80000000)
                    send_word(REQ_PUSH, idx, unsorted_value(idx));
                else
                    send_word(REQ_PUSH, idx, $urandom);
            end
            else if (pick < 95)
            begin
                if (cnt < MAX_LISTS)
                    send_word(REQ_PUSH, $urandom_range(cnt, MAX_LISTS - 1), $urandom);
                else
                    send_word(REQ_PUSH, idx, sorted_value(idx));
            end
            else if (pick < 98)
                send_word(REQ_CLEAR, $urandom, $urandom);
            else
                send_word(REQ_NOP, $urandom, $urandom);
        end
    endtask

    task automatic test_random();
        set_list_count(1);
        run_random_phase(70, 1'b0);
        set_list_count(3);
        run_random_phase(80, 1'b1);
        set_list_count(MAX_LISTS);
        run_random_phase(80, 1'b0);
        set_list_count(127);
        idle_pct = 0;
        run_random_phase(70, 1'b0);
        idle_pct = 31;
        set_list_count(0);
        run_random_phase(60, 1'b0);
        set_list_count(8);
        run_random_phase(70, 1'b0);
        set_list_count($urandom_range(1, 127));
        run_random_phase(70, 1'b0);
    endtask

    // timeout
    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < MAX_LISTS; i++)
        begin
            fill_cnt[i] = 0;
            head_cnt[i] = 0;
        end
        list_count_reg = LIST_COUNT_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_list();
        test_random();

        wait_drained();
        repeat (100) @(posedge clk);
        if (mismatch_cnt == 0 && merge_results_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
